FILE: src/mvtk_pkg.sv
// Shared types and constants for the moment vector top-k match block.
// Used by mvtk_ctrl, mvtk_dp and moment_vector_topk_match_top.
package mvtk_pkg;

	localparam logic [2:0] OP_QMOM   = 3'd0;
	localparam logic [2:0] OP_QMASS  = 3'd1;
	localparam logic [2:0] OP_HEADER = 3'd2;
	localparam logic [2:0] OP_EMOM   = 3'd3;
	localparam logic [2:0] OP_FINISH = 3'd4;

	localparam logic [1:0] REG_TOP_COUNT    = 2'd0;
	localparam logic [1:0] REG_MASS_WEIGHT  = 2'd1;
	localparam logic [1:0] REG_MASS_DIVISOR = 2'd2;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 41;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_MOM    = 11'b00000000010,
		ST_ACC    = 11'b00000000100,
		ST_DIV    = 11'b00000001000,
		ST_MSQ    = 11'b00000010000,
		ST_MWT    = 11'b00000100000,
		ST_SQRT   = 11'b00001000000,
		ST_INS    = 11'b00010000000,
		ST_EMIT   = 11'b00100000000,
		ST_HOLD   = 11'b01000000000,
		ST_SUM    = 11'b10000000000
	} state_t;

	typedef struct packed {
		logic load_item;
		logic load_mass;
		logic load_header;
		logic mom_read;
		logic mom_acc;
		logic div_start;
		logic div_step;
		logic msq;
		logic mwt;
		logic sqrt_start;
		logic sqrt_step;
		logic insert;
		logic emit;
		logic finish_clear;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       entry_end;
		logic       div_done;
		logic       sqrt_done;
		logic       emit_done;
	} status_t;

endpackage

FILE: src/moment_vector_topk_match_top.sv
// Nearest-match search over streamed moment vectors.
// Query moments (op 0) and query mass (op 1) are loaded first. Entries follow as
// a header (op 2) and moment beats (op 3, entry_end on the final one). A finish
// beat (op 4) emits the best matches, lowest score first, one per cycle.
// A beat is accepted when start is high and busy is low. Results appear for one
// cycle with strobe high; the receiver cannot stall them.
// Load and header beats are registered and stored; moment beats also read the
// query moment, square the difference and add it to the sum. A closing moment
// beat then runs a 41-step divider for the query mass quotient, two multiply
// stages and a sum stage for the mass term and a 32-step square root unit.
// Reset empties the best list, clears the sums and returns the registers to
// their defaults; query moments must be written before they are used.
// Configuration writes must be made when the block is idle; nothing enforces it.
module moment_vector_topk_match_top #(
	parameter int MOMENTS = 64,
	parameter int MAX_TOP = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic [7:0]         index,
	input  logic signed [31:0] value,
	input  logic [15:0]        entry_id,
	input  logic               entry_end,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output logic               strobe,
	output logic [15:0]        match_id,
	output logic [31:0]        score,
	output logic               found,
	output logic               last
);

	logic [2:0]  top_count_q;
	logic [16:0] mass_weight_q;
	logic [12:0] mass_div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= 3'd3;
			mass_weight_q <= 17'd65536;
			mass_div_q <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mvtk_pkg::REG_TOP_COUNT:    top_count_q <= cfg_data[2:0];
				mvtk_pkg::REG_MASS_WEIGHT:  mass_weight_q <= cfg_data;
				mvtk_pkg::REG_MASS_DIVISOR: mass_div_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	mvtk_pkg::cmd_t    cmd;
	mvtk_pkg::status_t status;

	mvtk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.status(status), .cmd(cmd)
	);

	mvtk_dp #(.MOMENTS(MOMENTS), .MAX_TOP(MAX_TOP)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.op(op), .index(index), .value(value), .entry_id(entry_id),
		.entry_end(entry_end), .top_count(top_count_q),
		.mass_weight(mass_weight_q), .mass_div(mass_div_q),
		.match_id(match_id), .score(score), .found(found), .last(last),
		.strobe(strobe)
	);

endmodule

FILE: src/mvtk_ctrl.sv
// Controller state machine for the moment vector top-k match block.
// Depends on mvtk_pkg; drives mvtk_dp through cmd_t and reads status_t.
module mvtk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mvtk_pkg::status_t   status,
	output mvtk_pkg::cmd_t      cmd
);

	mvtk_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			mvtk_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					state_d = mvtk_pkg::ST_HOLD;
				end
			end
			mvtk_pkg::ST_HOLD: begin
				priority if (status.op == mvtk_pkg::OP_EMOM) begin
					cmd.mom_read = 1'b1;
					state_d = mvtk_pkg::ST_MOM;
				end else if (status.op == mvtk_pkg::OP_FINISH) begin
					state_d = mvtk_pkg::ST_EMIT;
				end else begin
					cmd.load_mass = (status.op == mvtk_pkg::OP_QMASS);
					cmd.load_header = (status.op == mvtk_pkg::OP_HEADER);
					state_d = mvtk_pkg::ST_IDLE;
				end
			end
			mvtk_pkg::ST_MOM: begin
				cmd.mom_acc = 1'b1;
				state_d = mvtk_pkg::ST_ACC;
			end
			mvtk_pkg::ST_ACC: begin
				if (status.entry_end) begin
					cmd.div_start = 1'b1;
					state_d = mvtk_pkg::ST_DIV;
				end else begin
					state_d = mvtk_pkg::ST_IDLE;
				end
			end
			mvtk_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_d = mvtk_pkg::ST_MSQ;
			end
			mvtk_pkg::ST_MSQ: begin
				cmd.msq = 1'b1;
				state_d = mvtk_pkg::ST_MWT;
			end
			mvtk_pkg::ST_MWT: begin
				cmd.mwt = 1'b1;
				state_d = mvtk_pkg::ST_SUM;
			end
			mvtk_pkg::ST_SUM: begin
				cmd.sqrt_start = 1'b1;
				state_d = mvtk_pkg::ST_SQRT;
			end
			mvtk_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (status.sqrt_done) state_d = mvtk_pkg::ST_INS;
			end
			mvtk_pkg::ST_INS: begin
				cmd.insert = 1'b1;
				state_d = mvtk_pkg::ST_IDLE;
			end
			mvtk_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_done) begin
					cmd.finish_clear = 1'b1;
					state_d = mvtk_pkg::ST_IDLE;
				end
			end
			default: state_d = mvtk_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mvtk_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != mvtk_pkg::ST_IDLE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |-> state_q == mvtk_pkg::ST_IDLE)
		else $error("item loaded while busy");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> busy)
		else $error("not busy after accept");

endmodule

FILE: src/mvtk_dp.sv
// Datapath: query store, accumulator, divider, mass term, square root, best list.
// Depends on mvtk_pkg; controlled by mvtk_ctrl.
module mvtk_dp #(
	parameter int MOMENTS = 64,
	parameter int MAX_TOP = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mvtk_pkg::cmd_t      cmd,
	output mvtk_pkg::status_t   status,
	input  logic [2:0]          op,
	input  logic [7:0]          index,
	input  logic signed [31:0]  value,
	input  logic [15:0]         entry_id,
	input  logic                entry_end,
	input  logic [2:0]          top_count,
	input  logic [16:0]         mass_weight,
	input  logic [12:0]         mass_div,
	output logic [15:0]         match_id,
	output logic [31:0]         score,
	output logic                found,
	output logic                last,
	output logic                strobe
);

	localparam int AW = (MOMENTS > 1) ? $clog2(MOMENTS) : 1;
	localparam int FW = $clog2(MAX_TOP + 1);
	localparam int PW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;

	logic signed [31:0] qmem [MOMENTS];

	logic [2:0]         op_q;
	logic [7:0]         index_q;
	logic signed [31:0] value_q;
	logic [15:0]        eid_q;
	logic               end_q;
	logic signed [31:0] target_q;
	logic [63:0]        dsum_q;
	logic [15:0]        cur_id_q;
	logic signed [31:0] cur_mass_q;
	logic signed [31:0] qrd_q;
	logic               inr_q;
	logic [63:0]        sq_q;

	logic               idx_ok;
	assign idx_ok = ({24'd0, index_q} < 32'(MOMENTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			end_q <= 1'b0;
		end else if (cmd.load_item) begin
			op_q <= op;
			end_q <= entry_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			index_q <= index;
			value_q <= value;
			eid_q <= entry_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item && op == mvtk_pkg::OP_QMOM &&
		    {24'd0, index} < 32'(MOMENTS))
			qmem[index[AW-1:0]] <= value;
		if (cmd.mom_read) qrd_q <= qmem[index_q[AW-1:0]];
	end

	// Moment difference squared, one multiply per moment beat.
	logic [31:0] mdiff;
	always_comb begin
		logic signed [32:0] d;
		d = 33'(qrd_q) - 33'(value_q);
		mdiff = d[32] ? 32'(-d) : 32'(d);
	end

	always_ff @(posedge clk) begin
		if (cmd.mom_read) inr_q <= idx_ok;
		if (cmd.mom_acc) sq_q <= 64'(mdiff) * 64'(mdiff);
	end

	// Restoring divider for the query mass quotient.
	logic [40:0] dnum_q, dquo_q;
	logic [40:0] drem_q;
	logic        dneg_q;
	logic [5:0]  dcnt_q;
	logic [12:0] divisor;
	assign divisor = (mass_div == '0) ? 13'd1 : mass_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= 6'(mvtk_pkg::DIV_STEPS);
		else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q <= target_q[31] ? 41'(-{{9{target_q[31]}}, target_q} <<< 8) :
			          41'({9'd0, target_q} << 8);
			dneg_q <= target_q[31];
			drem_q <= '0;
			dquo_q <= '0;
		end else if (cmd.div_step && dcnt_q != '0) begin
			logic [41:0] tr;
			tr = {drem_q, dnum_q[40]};
			dnum_q <= {dnum_q[39:0], 1'b0};
			if (tr >= 42'(divisor)) begin
				drem_q <= 41'(tr - 42'(divisor));
				dquo_q <= {dquo_q[39:0], 1'b1};
			end else begin
				drem_q <= tr[40:0];
				dquo_q <= {dquo_q[39:0], 1'b0};
			end
		end
	end

	assign status.div_done = (dcnt_q == 6'd1);

	// Mass term: d = entry mass - quotient, squared, then weighted.
	logic signed [42:0] quot_s;
	logic signed [42:0] mdel;
	logic [42:0]        mabs;
	assign quot_s = dneg_q ? -$signed({2'b0, dquo_q}) : $signed({2'b0, dquo_q});
	assign mdel = 43'(cur_mass_q) - quot_s;
	assign mabs = mdel[42] ? 43'(-mdel) : 43'(mdel);

	logic [63:0] msq_q;
	logic        mbig_q;
	logic [63:0] mterm;
	logic [63:0] mterm_q;

	always_ff @(posedge clk) begin
		if (cmd.msq) begin
			mbig_q <= (mabs[42:32] != '0);
			msq_q <= 64'(mabs[31:0]) * 64'(mabs[31:0]);
		end
	end

	logic [47:0] hi_w;
	logic [64:0] hi_prod;
	logic [32:0] lo_prod;
	logic [64:0] msum;
	assign hi_w = msq_q[63:16];
	assign hi_prod = 65'(hi_w) * 65'(mass_weight);
	assign lo_prod = 33'(msq_q[15:0]) * 33'(mass_weight);
	assign msum = hi_prod + 65'(lo_prod[32:16]);

	always_comb begin
		if (mass_weight == '0) mterm = '0;
		else if (mbig_q || msum[64]) mterm = '1;
		else mterm = msum[63:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mwt) mterm_q <= mterm;
	end

	logic [64:0] tot;
	assign tot = 65'(dsum_q) + 65'(mterm_q);

	// Bit-pair square root, one result bit per cycle.
	logic [63:0] srem_q, sval_q;
	logic [31:0] sroot_q;
	logic [5:0]  scnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scnt_q <= '0;
		else if (cmd.sqrt_start) scnt_q <= 6'(mvtk_pkg::SQRT_STEPS);
		else if (cmd.sqrt_step && scnt_q != '0) scnt_q <= scnt_q - 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sval_q <= tot[64] ? '1 : tot[63:0];
			srem_q <= '0;
			sroot_q <= '0;
		end else if (cmd.sqrt_step && scnt_q != '0) begin
			logic [65:0] r;
			logic [65:0] t;
			r = {srem_q, sval_q[63:62]};
			t = {32'd0, sroot_q, 2'b01};
			sval_q <= {sval_q[61:0], 2'b00};
			if (r >= t) begin
				srem_q <= 64'(r - t);
				sroot_q <= {sroot_q[30:0], 1'b1};
			end else begin
				srem_q <= r[63:0];
				sroot_q <= {sroot_q[30:0], 1'b0};
			end
		end
	end

	assign status.sqrt_done = (scnt_q == 6'd1);

	// Best list.
	logic [15:0] bid_q [MAX_TOP];
	logic [31:0] bsc_q [MAX_TOP];
	logic [FW-1:0] fill_q;
	logic [PW-1:0] ecnt_q;
	logic [FW-1:0] ncount;
	logic [FW-1:0] kcl;

	always_comb begin
		if (top_count == 3'd0) kcl = FW'(1);
		else if (32'(top_count) > 32'(MAX_TOP)) kcl = FW'(MAX_TOP);
		else kcl = FW'(top_count);
		ncount = (fill_q < kcl) ? fill_q : kcl;
	end

	logic [MAX_TOP-1:0] gt;
	always_comb begin
		for (int i = 0; i < MAX_TOP; i++)
			gt[i] = (32'(i) < 32'(fill_q)) && (bsc_q[i] > sroot_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < MAX_TOP; i++) begin
				if (gt[i] || 32'(i) == 32'(fill_q)) begin
					if (i == 0 || !(gt[i-((i>0)?1:0)] && i > 0)) begin
						bid_q[i] <= cur_id_q;
						bsc_q[i] <= sroot_q;
					end else begin
						bid_q[i] <= bid_q[i-1];
						bsc_q[i] <= bsc_q[i-1];
					end
				end
			end
		end
	end

	assign status.emit_done = (ncount == '0) || (32'(ecnt_q) + 1 == 32'(ncount));

	logic        acc_pend_q;
	logic        acc_en;
	logic [63:0] acc_val;
	logic [64:0] acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_pend_q <= 1'b0;
		else acc_pend_q <= cmd.mom_acc;
	end

	assign acc_sum = 65'(dsum_q) + 65'(sq_q);
	assign acc_en = (op_q == mvtk_pkg::OP_EMOM) && inr_q && acc_pend_q;
	assign acc_val = acc_sum[64] ? '1 : acc_sum[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			dsum_q <= '0;
			cur_id_q <= '0;
			cur_mass_q <= '0;
			fill_q <= '0;
			ecnt_q <= '0;
			strobe <= 1'b0;
			match_id <= '0;
			score <= '0;
			found <= 1'b0;
			last <= 1'b0;
		end else begin
			if (cmd.load_mass) target_q <= value_q;
			if (cmd.load_header) begin
				cur_id_q <= eid_q;
				cur_mass_q <= value_q;
			end
			if (cmd.load_header || cmd.insert || cmd.finish_clear) dsum_q <= '0;
			else if (acc_en) dsum_q <= acc_val;
			if (cmd.finish_clear) fill_q <= '0;
			else if (cmd.insert && 32'(fill_q) < 32'(MAX_TOP)) fill_q <= fill_q + FW'(1);
			strobe <= cmd.emit;
			if (cmd.emit) begin
				if (ncount == '0) begin
					match_id <= '0;
					score <= '0;
					found <= 1'b0;
					last <= 1'b1;
				end else begin
					match_id <= bid_q[ecnt_q];
					score <= bsc_q[ecnt_q];
					found <= 1'b1;
					last <= status.emit_done;
				end
				ecnt_q <= status.emit_done ? '0 : ecnt_q + PW'(1);
			end
		end
	end

	assign status.op = op_q;
	assign status.entry_end = end_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(MAX_TOP))
		else $error("best list overfilled");
	a_strobe_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(cmd.emit))
		else $error("strobe without emit");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_clear |=> fill_q == '0)
		else $error("list not cleared after finish");

endmodule

FILE: bench/moment_vector_topk_match_top_tb.sv
// Self-checking testbench for moment_vector_topk_match_top.
// Depends on mvtk_pkg and the block's RTL. It drives query, entry and finish beats
// and checks every emitted best match against a built-in predictor.
`timescale 1ns / 1ps

module moment_vector_topk_match_top_tb;

	localparam int NMOM = 64;
	localparam int NTOP = 5;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [15:0] id;
		logic [31:0] score;
		logic        found;
		logic        last;
	} match_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         op;
	logic [7:0]         index;
	logic signed [31:0] value;
	logic [15:0]        entry_id;
	logic               entry_end;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [16:0]        cfg_data;
	logic               strobe;
	logic [15:0]        match_id;
	logic [31:0]        score;
	logic               found;
	logic               last;

	moment_vector_topk_match_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .index(index), .value(value), .entry_id(entry_id),
		.entry_end(entry_end), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .match_id(match_id),
		.score(score), .found(found), .last(last)
	);

	// Predictor state.
	logic [2:0]  keep_count;
	logic [16:0] mass_wt;
	logic [12:0] mass_div;
	longint      query_vec[NMOM];
	bit          query_set[NMOM];
	longint      query_mass;
	logic [63:0] dist_acc;
	logic [15:0] cur_id;
	longint      cur_mass;
	logic [15:0] rank_id[NTOP];
	logic [31:0] rank_score[NTOP];
	int          rank_fill;

	match_t      expected_matches[$];
	int          errors;
	int          beats_sent;
	int          matches_seen;
	int          cycles;
	bit          idling;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		match_t want;
		if (arst_n && strobe) begin
			matches_seen++;
			if (expected_matches.size() == 0) begin
				report($sformatf("unexpected result id=%h score=%h", match_id, score));
			end else begin
				want = expected_matches.pop_front();
				if (match_id !== want.id)
					report($sformatf("match_id %h, expected %h", match_id, want.id));
				if (score !== want.score)
					report($sformatf("score %h, expected %h", score, want.score));
				if (found !== want.found)
					report($sformatf("found %b, expected %b", found, want.found));
				if (last !== want.last)
					report($sformatf("last %b, expected %b", last, want.last));
			end
		end
	end

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL_ONES : s[63:0];
	endfunction

	function automatic logic [63:0] abs_delta(input longint a, input longint b);
		longint d;
		d = a - b;
		return (d < 0) ? -d : d;
	endfunction

	function automatic logic [31:0] int_sqrt(input logic [63:0] x);
		logic [63:0] rem, root, bitv;
		rem = x;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root[31:0];
	endfunction

	function automatic logic [63:0] mass_penalty();
		longint      divisor, quot;
		logic [63:0] d, sq, hi, lo, prod, wt;
		divisor = (mass_div == 0) ? 1 : longint'(mass_div);
		quot = (query_mass * 256) / divisor;
		d = abs_delta(cur_mass, quot);
		wt = mass_wt;
		if (wt == 0)
			return 64'd0;
		if (d >= 64'h1_0000_0000)
			return ALL_ONES;
		sq = d * d;
		hi = sq >> 16;
		lo = sq & 64'hFFFF;
		if (hi > ALL_ONES / wt)
			return ALL_ONES;
		prod = hi * wt;
		return add_sat(prod, (lo * wt) >> 16);
	endfunction

	function automatic void rank_insert(input logic [15:0] id, input logic [31:0] sc);
		int pos, i;
		pos = 0;
		while (pos < rank_fill && rank_score[pos] <= sc)
			pos++;
		if (pos >= NTOP)
			return;
		i = (rank_fill < NTOP) ? rank_fill : NTOP - 1;
		for (; i > pos; i--) begin
			rank_id[i] = rank_id[i - 1];
			rank_score[i] = rank_score[i - 1];
		end
		rank_id[pos] = id;
		rank_score[pos] = sc;
		if (rank_fill < NTOP)
			rank_fill++;
	endfunction

	function automatic void predict_beat(input logic [2:0] b_op, input logic [7:0] b_idx,
			input logic signed [31:0] b_val, input logic [15:0] b_id, input logic b_end);
		int     k, n;
		match_t m;
		case (b_op)
			mvtk_pkg::OP_QMOM: begin
				if (b_idx < NMOM) begin
					query_vec[b_idx] = b_val;
					query_set[b_idx] = 1'b1;
				end
			end
			mvtk_pkg::OP_QMASS: query_mass = b_val;
			mvtk_pkg::OP_HEADER: begin
				cur_id = b_id;
				cur_mass = b_val;
				dist_acc = 0;
			end
			mvtk_pkg::OP_EMOM: begin
				if (b_idx < NMOM)
					dist_acc = add_sat(dist_acc, abs_delta(query_vec[b_idx], b_val) *
						abs_delta(query_vec[b_idx], b_val));
				if (b_end) begin
					rank_insert(cur_id, int_sqrt(add_sat(dist_acc, mass_penalty())));
					dist_acc = 0;
				end
			end
			mvtk_pkg::OP_FINISH: begin
				k = keep_count;
				if (k == 0)
					k = 1;
				if (k > NTOP)
					k = NTOP;
				n = (rank_fill < k) ? rank_fill : k;
				if (n == 0) begin
					m = '{id: 16'd0, score: 32'd0, found: 1'b0, last: 1'b1};
					expected_matches.push_back(m);
				end
				for (int i = 0; i < n; i++) begin
					m = '{id: rank_id[i], score: rank_score[i], found: 1'b1,
						last: (i + 1 == n)};
					expected_matches.push_back(m);
				end
				rank_fill = 0;
				dist_acc = 0;
			end
			default: ;
		endcase
	endfunction

	// Called after a rising edge; returns once the beat is taken, plus any idle pause.
	task automatic send_beat(input logic [2:0] b_op, input logic [7:0] b_idx,
			input logic signed [31:0] b_val, input logic [15:0] b_id, input logic b_end);
		op <= b_op;
		index <= b_idx;
		value <= b_val;
		entry_id <= b_id;
		entry_end <= b_end;
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		predict_beat(b_op, b_idx, b_val, b_id, b_end);
		beats_sent++;
		if (idling && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mvtk_pkg::REG_TOP_COUNT:    keep_count = data[2:0];
			mvtk_pkg::REG_MASS_WEIGHT:  mass_wt = data;
			mvtk_pkg::REG_MASS_DIVISOR: mass_div = data[12:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	function automatic logic [7:0] pick_moment_index();
		int i;
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(NMOM, 255));
		do
			i = $urandom_range(0, NMOM - 1);
		while (!query_set[i]);
		return 8'(i);
	endfunction

	task automatic send_entry(input logic [15:0] id, input int nmom);
		send_beat(mvtk_pkg::OP_HEADER, 8'($urandom), pick_value(), id, 1'b0);
		for (int i = 0; i < nmom; i++)
			send_beat(mvtk_pkg::OP_EMOM, pick_moment_index(), pick_value(),
				16'($urandom), i == nmom - 1);
	endtask

	task automatic test_directed();
		send_beat(mvtk_pkg::OP_FINISH, 8'd0, 32'sd0, 16'd0, 1'b0);
		for (int i = 0; i < 4; i++)
			send_beat(mvtk_pkg::OP_QMOM, 8'(i),
				(i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF, 16'd0, 1'b0);
		send_beat(mvtk_pkg::OP_QMOM, 8'(NMOM - 1), 32'sh0001_0000, 16'd0, 1'b0);
		send_beat(mvtk_pkg::OP_QMOM, 8'd255, 32'sh1234_5678, 16'd0, 1'b0);
		send_beat(mvtk_pkg::OP_QMASS, 8'd0, 32'sh0010_0000, 16'd0, 1'b0);
		// Largest differences drive the moment sum into saturation.
		send_beat(mvtk_pkg::OP_HEADER, 8'd0, 32'sh8000_0000, 16'hFFFF, 1'b0);
		send_beat(mvtk_pkg::OP_EMOM, 8'd0, 32'sh8000_0000, 16'd0, 1'b0);
		send_beat(mvtk_pkg::OP_EMOM, 8'd1, 32'sh7FFF_FFFF, 16'd0, 1'b0);
		send_beat(mvtk_pkg::OP_EMOM, 8'd2, 32'sh8000_0000, 16'd0, 1'b1);
		// Moments without a header reuse the current id and mass.
		send_beat(mvtk_pkg::OP_EMOM, 8'(NMOM - 1), 32'sh0001_0000, 16'd0, 1'b1);
		send_beat(mvtk_pkg::OP_EMOM, 8'(NMOM - 1), 32'sh0001_0000, 16'd0, 1'b1);
		// A header in the middle of an entry drops its partial sum.
		send_beat(mvtk_pkg::OP_HEADER, 8'd0, 32'sh0010_0000, 16'h0001, 1'b0);
		send_beat(mvtk_pkg::OP_EMOM, 8'd3, 32'sh0000_0000, 16'd0, 1'b0);
		send_beat(mvtk_pkg::OP_HEADER, 8'd0, 32'sh0010_0000, 16'h0002, 1'b0);
		send_beat(mvtk_pkg::OP_EMOM, 8'd200, 32'sh7FFF_FFFF, 16'd0, 1'b1);
		for (int u = 5; u < 8; u++)
			send_beat(3'(u), 8'd0, 32'sh0, 16'd0, 1'b1);
		send_beat(mvtk_pkg::OP_FINISH, 8'd0, 32'sh0, 16'd0, 1'b0);
		settle();
	endtask

	task automatic test_query_fill();
		for (int i = 0; i < NMOM; i++)
			send_beat(mvtk_pkg::OP_QMOM, 8'(i), pick_value(), 16'd0, 1'b0);
	endtask

	task automatic test_search_round();
		int nent;
		if ($urandom_range(0, 3) == 0)
			send_beat(mvtk_pkg::OP_QMOM, 8'($urandom), pick_value(), 16'd0, 1'b0);
		if ($urandom_range(0, 1))
			send_beat(mvtk_pkg::OP_QMASS, 8'($urandom), pick_value(), 16'($urandom), 1'b0);
		nent = $urandom_range(0, 7);
		for (int e = 0; e < nent; e++) begin
			if ($urandom_range(0, 7) == 0)
				send_beat(3'($urandom), 8'($urandom), $urandom, 16'($urandom), 1'($urandom));
			send_entry(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) :
				16'($urandom), $urandom_range(1, 6));
		end
		send_beat(mvtk_pkg::OP_FINISH, 8'($urandom), $urandom, 16'($urandom),
			1'($urandom));
	endtask

	task automatic test_config_sweep(input logic [2:0] top, input logic [16:0] wt,
			input logic [12:0] div, input int rounds);
		settle();
		write_reg(mvtk_pkg::REG_TOP_COUNT, 17'(top));
		write_reg(mvtk_pkg::REG_MASS_WEIGHT, wt);
		write_reg(mvtk_pkg::REG_MASS_DIVISOR, 17'(div));
		@(posedge clk);
		for (int r = 0; r < rounds; r++)
			test_search_round();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = mvtk_pkg::OP_QMOM;
		index = 8'd0;
		value = 32'sd0;
		entry_id = 16'd0;
		entry_end = 1'b0;
		cfg_we = 1'b0;
		cfg_index = mvtk_pkg::REG_TOP_COUNT;
		cfg_data = 17'd0;
		errors = 0;
		beats_sent = 0;
		matches_seen = 0;
		cycles = 0;
		idling = 1'b1;
		keep_count = 3'd3;
		mass_wt = 17'd65536;
		mass_div = 13'd256;
		query_mass = 0;
		dist_acc = 0;
		cur_id = 0;
		cur_mass = 0;
		rank_fill = 0;
		foreach (query_set[i]) begin
			query_set[i] = 1'b0;
			query_vec[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_query_fill();
		test_config_sweep(3'd5, 17'd65536, 13'd13, 4);
		test_config_sweep(3'd1, 17'd0, 13'd5120, 3);
		test_config_sweep(3'd0, 17'd1, 13'd0, 3);
		test_config_sweep(3'd7, 17'h1FFFF, 13'h1FFF, 3);
		while (beats_sent < 400) begin
			idling = (beats_sent < 330) ? ($urandom_range(0, 3) != 0) : 1'b0;
			test_config_sweep(3'($urandom_range(1, 5)), 17'($urandom_range(0, 65536)),
				13'($urandom_range(13, 5120)), 3);
		end
		settle();

		$display("Sent %0d beats over several register settings; checked %0d results.",
			beats_sent, matches_seen);
		if (errors == 0 && expected_matches.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
